// ===== sv/zcmbs_pkg.sv =====
// Shared types and constants for the zero-crossing bit slicer.
`default_nettype none
package zcmbs_pkg;

  // Datapath sizing
  localparam int SAMPLE_BITS = 16;
  localparam int MEAN_SHIFT  = 10;
  localparam int SUM_W       = 32;
  localparam int ACC_W       = 40;
  localparam int GAP_W       = 16;
  localparam int MEAN_W      = SUM_W - MEAN_SHIFT;  // integer mean, sample units
  localparam int DIFF_W      = MEAN_W + 1;          // sample - mean, no overflow

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_GAP = CFG_IDX_W'(1);

  localparam logic [GAP_W-1:0] MIN_GAP_RST  = GAP_W'(7);
  localparam logic [GAP_W-1:0] HALF_GAP_RST = GAP_W'(5);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Gap settings handed to the decision stage
  typedef struct packed {
    logic [GAP_W-1:0] min_gap;
    logic [GAP_W-1:0] half_gap;
  } cfg_t;

  // Mean stage result for one sample
  typedef struct packed {
    logic                     crossed;
    logic signed [DIFF_W-1:0] diff;
  } mean_res_t;

endpackage
`default_nettype wire

// ===== sv/zcmbs_in_if.sv =====
// Input sample channel.
`default_nettype none
interface zcmbs_in_if
  import zcmbs_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== sv/zcmbs_out_if.sv =====
// Decided bit channel.
`default_nettype none
interface zcmbs_out_if;
  logic valid;
  logic ready;
  logic bit_res;

  modport source (output valid, output bit_res, input ready);
  modport sink   (input valid, input bit_res, output ready);
endinterface
`default_nettype wire

// ===== sv/zcmbs_cfg_if.sv =====
// Configuration write channel.
`default_nettype none
interface zcmbs_cfg_if
  import zcmbs_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/zcmbs_mean.sv =====
// Running mean tracker and mean-crossing detector (first pipeline stage).
`default_nettype none
module zcmbs_mean
  import zcmbs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire sample_t   sample,
  output mean_res_t      res
);

  logic signed [SUM_W-1:0]       mean_sum_r, mean_sum_nxt;
  sample_t                       prev_r;
  mean_res_t                     res_r, res_nxt;
  logic signed [SUM_W-1:0]       sum_shr;
  logic signed [SUM_W+1:0]       sum_wide;
  logic signed [MEAN_W-1:0]      mean;
  logic signed [DIFF_W-1:0]      xe, me, pe;

  // Leaky sum: sum - floor(sum / 2^MEAN_SHIFT) + sample, saturated to 32 bits
  always_comb begin
    sum_shr  = mean_sum_r >>> MEAN_SHIFT;
    sum_wide = (SUM_W+2)'(mean_sum_r) - (SUM_W+2)'(sum_shr) + (SUM_W+2)'(sample);
    if (sum_wide[SUM_W+1] != sum_wide[SUM_W] || sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      mean_sum_nxt = sum_wide[SUM_W+1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      mean_sum_nxt = sum_wide[SUM_W-1:0];
    end
  end

  // Floor mean, crossing test and deviation from the mean
  always_comb begin
    mean = mean_sum_nxt[SUM_W-1:MEAN_SHIFT];
    xe   = DIFF_W'(sample);
    me   = DIFF_W'(mean);
    pe   = DIFF_W'(prev_r);
    res_nxt.crossed = (pe <= me && xe > me) || (pe >= me && xe < me);
    res_nxt.diff    = xe - me;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_sum_r <= '0;
      prev_r     <= '0;
    end else if (en) begin
      mean_sum_r <= mean_sum_nxt;
      prev_r     <= sample;
    end
  end

  // Stage result, payload only
  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

  // A crossing always means the sample is strictly off the mean
  a_cross_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> !(res_r.crossed && res_r.diff == '0))
    else $error("crossing flagged with zero deviation");

endmodule
`default_nettype wire

// ===== sv/zcmbs_decide.sv =====
// Crossing judgement, elapsed counter and half-wave accumulator (second stage).
`default_nettype none
module zcmbs_decide
  import zcmbs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      go,
  input  wire mean_res_t s1,
  input  wire cfg_t      cfg,
  output logic           produced,
  output logic           bit_res
);

  localparam logic [GAP_W-1:0] ELAPSED_MAX = '1;

  logic [GAP_W-1:0]        elapsed_r, elapsed_nxt, el_inc;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, acc_base;
  logic signed [ACC_W:0]   acc_sum;
  logic                    reject;

  always_comb begin
    el_inc   = (elapsed_r != ELAPSED_MAX) ? elapsed_r + GAP_W'(1) : elapsed_r;
    reject   = s1.crossed && (el_inc < cfg.min_gap);
    produced = s1.crossed && !reject;
    // zero when the half-wave sum is positive
    bit_res  = !(!acc_r[ACC_W-1] && acc_r != '0);

    // Clear on any crossing, restart the count on an accepted one
    acc_base    = s1.crossed ? '0 : acc_r;
    elapsed_nxt = produced ? '0 : el_inc;

    // Saturating accumulate during the second half of the wave
    acc_sum = (ACC_W+1)'(acc_base) + (ACC_W+1)'($signed(s1.diff));
    acc_nxt = acc_base;
    if (!reject && elapsed_nxt > cfg.half_gap) begin
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
        acc_nxt = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                 : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_nxt = acc_sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      acc_r     <= '0;
    end else if (go) begin
      elapsed_r <= elapsed_nxt;
      acc_r     <= acc_nxt;
    end
  end

  a_clear_on_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (go && produced) |=> (acc_r == '0 && elapsed_r == '0))
    else $error("state not restarted after a decided bit");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !s1.crossed && elapsed_r != ELAPSED_MAX) |=>
      elapsed_r == $past(elapsed_r) + GAP_W'(1))
    else $error("elapsed count did not advance");

  a_reject_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && reject) |=> (acc_r == '0))
    else $error("rejected crossing left the accumulator set");

endmodule
`default_nettype wire

// ===== sv/zero_crossing_msk_bit_slicer_top.sv =====
// Zero-crossing MSK bit slicer: top level with config registers and output register.
//
// Usage:
//   in_ch  : one signed 16-bit discriminator sample per word (valid/ready).
//   out_ch : one decided bit per accepted mean crossing (valid/ready);
//            samples that decide nothing produce no word.
//   cfg_ch : register writes, index 0 = min_gap, 1 = half_gap; always ready.
//            Write only while no sample is in flight.
// Throughput: one sample per cycle while out_ch is not stalled. Stage one updates
// the running mean and flags the crossing; stage two judges it, updates the
// accumulator and loads the output register; the bit is valid from that register.
// The serial dependency per cycle is the 32-bit mean sum update in stage one
// and the 40-bit accumulator update in stage two.
// Reset (rst_n low, synchronous) clears the mean, previous sample, elapsed
// count and accumulator, empties the pipeline and loads min_gap = 7 and
// half_gap = 5.
// Stall: while the output word waits, one more sample is still taken into
// stage one; further samples wait until out_ch.ready returns.
`default_nettype none
module zero_crossing_msk_bit_slicer_top
  import zcmbs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  zcmbs_in_if.sink   in_ch,
  zcmbs_out_if.source out_ch,
  zcmbs_cfg_if.sink  cfg_ch
);

  cfg_t       cfg_r;
  logic       s1_v_r;
  logic       out_valid_r;
  logic       out_bit_r;
  logic       in_acc;
  logic       b_go;
  mean_res_t  s1_res;
  logic       produced;
  logic       bit_res;

  // Flow control: stage two moves when the output register is free or drains
  assign b_go         = s1_v_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || b_go;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_gap  <= MIN_GAP_RST;
      cfg_r.half_gap <= HALF_GAP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MIN_GAP:  cfg_r.min_gap  <= GAP_W'(cfg_ch.data);
        CFG_HALF_GAP: cfg_r.half_gap <= GAP_W'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  zcmbs_mean u_mean (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (in_acc),
    .sample (in_ch.sample),
    .res    (s1_res)
  );

  zcmbs_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (b_go),
    .s1       (s1_res),
    .cfg      (cfg_r),
    .produced (produced),
    .bit_res  (bit_res)
  );

  // Pipeline and output word valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (b_go) begin
        s1_v_r <= 1'b0;
      end
      if (b_go) begin
        out_valid_r <= produced;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (b_go && produced) begin
      out_bit_r <= bit_res;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.bit_res = out_bit_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while both stages are full");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(b_go))
    else $error("output word appeared without a stage advance");

endmodule
`default_nettype wire
